### hw/rtl/okle_pkg.sv
package okle_pkg;

	localparam int DEPTH       = 16;
	localparam int MAX_RESULTS = 16;
	localparam int LEN_W       = $clog2(DEPTH + 1);
	localparam int IDX_W       = $clog2(DEPTH);

	localparam int KIND_W  = 4;
	localparam int KEY_W   = 32;
	localparam int STAT_W  = 2;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;

	localparam logic [KIND_W-1:0] KIND_SORT_INS   = 4'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE     = 4'd1;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 4'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 4'd3;
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 4'd4;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 4'd5;
	localparam logic [KIND_W-1:0] KIND_REVERSE    = 4'd6;
	localparam logic [KIND_W-1:0] KIND_CLEAR      = 4'd7;
	localparam logic [KIND_W-1:0] KIND_DUMP       = 4'd8;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

	localparam logic [1:0] CELL_HOLD   = 2'd0;
	localparam logic [1:0] CELL_INSERT = 2'd1;
	localparam logic [1:0] CELL_DELETE = 2'd2;
	localparam logic [1:0] CELL_ROTATE = 2'd3;

	localparam logic [1:0] MATCH_NONE = 2'd0;
	localparam logic [1:0] MATCH_GE   = 2'd1;
	localparam logic [1:0] MATCH_EQ   = 2'd2;
	localparam logic [1:0] MATCH_ALL  = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic signed [KEY_W-1:0] key;
	} okle_in_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [KEY_W-1:0] element_key;
		logic [POS_W-1:0]        position;
		logic [COUNT_W-1:0]      count;
		logic                    last;
	} okle_out_t;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] mode;
		logic       valid;
		logic       at_len;
		logic       below_b;
		logic       at_b;
	} cell_ctl_t;

endpackage

### hw/rtl/okle_cell.sv
module okle_cell
	import okle_pkg::*;
(
	input  logic                    clk,
	input  cell_ctl_t               ctl,
	input  logic signed [KEY_W-1:0] key,
	input  logic signed [KEY_W-1:0] left_key,
	input  logic signed [KEY_W-1:0] right_key,
	input  logic signed [KEY_W-1:0] head_key,
	input  logic                    found_in,
	output logic                    found_out,
	output logic signed [KEY_W-1:0] key_q
);

	logic                    match;
	logic                    hit;
	logic signed [KEY_W-1:0] key_n;

	always_comb begin
		case (ctl.mode)
			MATCH_GE:  match = (key_q >= key);
			MATCH_EQ:  match = (key_q == key);
			MATCH_ALL: match = 1'b1;
			default:   match = 1'b0;
		endcase
	end

	assign hit       = ctl.valid && match;
	assign found_out = found_in || hit;

	always_comb begin
		key_n = key_q;
		unique case (ctl.op)
			CELL_HOLD: begin
				key_n = key_q;
			end
			CELL_INSERT: begin
				if (found_in) begin
					key_n = left_key;
				end else if (hit || ctl.at_len) begin
					key_n = key;
				end
			end
			CELL_DELETE: begin
				if (found_in || hit) begin
					key_n = right_key;
				end
			end
			CELL_ROTATE: begin
				if (ctl.below_b) begin
					key_n = right_key;
				end else if (ctl.at_b) begin
					key_n = head_key;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		key_q <= key_n;
	end

endmodule

### hw/rtl/okle_outq.sv
module okle_outq
	import okle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  okle_out_t push_word,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output okle_out_t out_word
);

	logic      v0_q, v1_q, v0_n, v1_n;
	okle_out_t w0_q, w1_q, w0_n, w1_n;
	logic      pop;

	assign pop       = v0_q && out_ready;
	assign room      = !v1_q || pop;
	assign out_valid = v0_q;
	assign out_word  = w0_q;

	always_comb begin
		v0_n = v0_q;
		v1_n = v1_q;
		w0_n = w0_q;
		w1_n = w1_q;
		if (pop) begin
			v0_n = v1_q;
			w0_n = w1_q;
			v1_n = 1'b0;
		end
		if (push) begin
			if (!v0_n) begin
				v0_n = 1'b1;
				w0_n = push_word;
			end else begin
				v1_n = 1'b1;
				w1_n = push_word;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			v0_q <= v0_n;
			v1_q <= v1_n;
		end
	end

	always_ff @(posedge clk) begin
		w0_q <= w0_n;
		w1_q <= w1_n;
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room) else $error("word pushed into full queue");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> v0_q) else $error("tail valid without head");

	a_tail_kept: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q && !pop |=> v1_q && $stable(w1_q)) else $error("waiting word lost");

endmodule

### hw/rtl/ordered_key_list_engine.sv
// single-result requests: accepted when idle and the output queue has room; the result is pushed in the same cycle
// reverse: after acceptance, rotation steps through the cell row, each shortening the rotated span by one
// dump: after acceptance, rotates the row once, emitting one word per element held;
// stalls with the output
// a two-word output queue lets a request be accepted while an earlier result waits
// reset clears the length, the sequencer and the output queue; cell keys are not reset
module ordered_key_list_engine
	import okle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  okle_in_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output okle_out_t out_word
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_REV  = 2'd1;
	localparam logic [1:0] S_DUMP = 2'd2;

	logic [1:0]       state_q, state_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic [IDX_W-1:0] b_q, b_n, k_q, k_n, b_sel;
	logic             in_fire, q_room, full, empty;
	logic [1:0]       cell_op, cell_mode;
	logic             push;
	okle_out_t        push_word;
	logic [STAT_W-1:0] res_status;
	logic             dump_emit, dump_end, dump_last;

	cell_ctl_t               ctl [DEPTH];
	logic signed [KEY_W-1:0] key_arr [DEPTH];
	logic [DEPTH:0]          found_w;

	assign in_ready = (state_q == S_IDLE) && q_room;
	assign in_fire  = in_valid && in_ready;
	assign full     = (len_q >= LEN_W'(DEPTH));
	assign empty    = (len_q == '0);

	assign dump_end  = (LEN_W'(k_q) + LEN_W'(1) == len_q);
	assign dump_emit = (int'(k_q) < MAX_RESULTS);
	assign dump_last = dump_end || (int'(k_q) == MAX_RESULTS - 1);

	// cell row control
	always_comb begin
		cell_op   = CELL_HOLD;
		cell_mode = MATCH_NONE;
		b_sel     = b_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					unique case (in_word.kind)
						KIND_SORT_INS: begin
							if (!full) begin
								cell_op   = CELL_INSERT;
								cell_mode = MATCH_GE;
							end
						end
						KIND_PUSH_BACK: begin
							if (!full) begin
								cell_op = CELL_INSERT;
							end
						end
						KIND_PUSH_FRONT: begin
							if (!full) begin
								cell_op   = CELL_INSERT;
								cell_mode = MATCH_ALL;
							end
						end
						KIND_DELETE: begin
							cell_op   = CELL_DELETE;
							cell_mode = MATCH_EQ;
						end
						KIND_POP_FRONT: begin
							cell_op   = CELL_DELETE;
							cell_mode = MATCH_ALL;
						end
						default: begin
							cell_op = CELL_HOLD;
						end
					endcase
				end
			end
			S_REV: begin
				cell_op = CELL_ROTATE;
			end
			S_DUMP: begin
				b_sel = IDX_W'(len_q - LEN_W'(1));
				if (!dump_emit || q_room) begin
					cell_op = CELL_ROTATE;
				end
			end
			default: begin
				cell_op = CELL_HOLD;
			end
		endcase
	end

	assign found_w[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign ctl[i] = '{
			op:      cell_op,
			mode:    cell_mode,
			valid:   (LEN_W'(i) < len_q),
			at_len:  (LEN_W'(i) == len_q),
			below_b: (IDX_W'(i) < b_sel),
			at_b:    (IDX_W'(i) == b_sel)
		};

		okle_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.key       (in_word.key),
			.left_key  ((i == 0) ? in_word.key : key_arr[(i == 0) ? 0 : i - 1]),
			.right_key ((i == DEPTH - 1) ? key_arr[i] : key_arr[(i == DEPTH - 1) ? i : i + 1]),
			.head_key  (key_arr[0]),
			.found_in  (found_w[i]),
			.found_out (found_w[i+1]),
			.key_q     (key_arr[i])
		);
	end

	// sequencer and results
	always_comb begin
		state_n    = state_q;
		len_n      = len_q;
		b_n        = b_q;
		k_n        = k_q;
		push       = 1'b0;
		res_status = STAT_OK;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					push = 1'b1;
					unique case (in_word.kind)
						KIND_SORT_INS, KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
							if (full) begin
								res_status = STAT_FULL;
							end else begin
								len_n = len_q + LEN_W'(1);
							end
						end
						KIND_DELETE: begin
							if (empty) begin
								res_status = STAT_EMPTY;
							end else if (found_w[DEPTH]) begin
								len_n = len_q - LEN_W'(1);
							end else begin
								res_status = STAT_NOT_FOUND;
							end
						end
						KIND_POP_BACK, KIND_POP_FRONT: begin
							if (empty) begin
								res_status = STAT_EMPTY;
							end else begin
								len_n = len_q - LEN_W'(1);
							end
						end
						KIND_REVERSE: begin
							if (empty) begin
								res_status = STAT_EMPTY;
							end else if (len_q >= LEN_W'(2)) begin
								state_n = S_REV;
								b_n     = IDX_W'(len_q - LEN_W'(1));
							end
						end
						KIND_CLEAR: begin
							len_n = '0;
						end
						KIND_DUMP: begin
							if (empty) begin
								res_status = STAT_EMPTY;
							end else begin
								push    = 1'b0;
								state_n = S_DUMP;
								k_n     = '0;
							end
						end
						default: begin
							res_status = STAT_OK;
						end
					endcase
				end
			end
			S_REV: begin
				b_n = b_q - IDX_W'(1);
				if (b_q == IDX_W'(1)) begin
					state_n = S_IDLE;
				end
			end
			S_DUMP: begin
				if (!dump_emit || q_room) begin
					push = dump_emit;
					k_n  = k_q + IDX_W'(1);
					if (dump_end) begin
						state_n = S_IDLE;
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_comb begin
		if (state_q == S_DUMP) begin
			push_word = '{
				status:      STAT_OK,
				element_key: key_arr[0],
				position:    POS_W'(k_q),
				count:       COUNT_W'(len_q),
				last:        dump_last
			};
		end else begin
			push_word = '{
				status:      res_status,
				element_key: '0,
				position:    '0,
				count:       COUNT_W'(len_n),
				last:        1'b1
			};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			b_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_n;
			len_q   <= len_n;
			b_q     <= b_n;
			k_q     <= k_n;
		end
	end

	okle_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.room      (q_room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule
